// ===== rtl/face_normal_grouper_top_defines.svh =====
// Assertion macros shared by the grouper RTL.
`ifndef FACE_NORMAL_GROUPER_TOP_DEFINES_SVH
`define FACE_NORMAL_GROUPER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define FNG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grouper assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define FNG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grouper assertion failed");

`endif

// ===== rtl/fng_pkg.sv =====
package fng_pkg;

    localparam int DW      = 17;   // vertex difference width
    localparam int NW      = 35;   // normal component width
    localparam int NNW     = 70;   // squared length width
    localparam int SW      = 72;   // signed accumulator width
    localparam int AW      = 104;  // multiplicand width of the MAC
    localparam int BW      = 72;   // multiplier width of the MAC
    localparam int PW      = 176;  // product width of the MAC
    localparam int LW      = 144;  // squared dot product width
    localparam int DIGW    = 8;    // multiplier digit width
    localparam int NDIG_MAX = 9;   // BW / DIGW
    localparam int NDW     = 4;    // digit count width
    localparam int GI_W    = 6;
    localparam int TOL_W   = 16;
    localparam int FRAC_SH = 32;   // left side scale, 2^32

    localparam logic [NDW-1:0] NDIG_COORD  = 4'd3;
    localparam logic [NDW-1:0] NDIG_NORMAL = 4'd5;
    localparam logic [NDW-1:0] NDIG_WIDE   = 4'd9;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_USE_GEOM  = 1'b0;
    localparam reg_idx_t REG_TOLERANCE = 1'b1;

    localparam logic               USE_GEOM_RST  = 1'b1;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST = 16'd66;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_NN,
        ST_RT,
        ST_CHECK,
        ST_DOT,
        ST_SQ,
        ST_RM,
        ST_NEWG,
        ST_RESTORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
        logic [NNW-1:0]       mm;
    } cell_t;

    typedef struct packed {
        logic           start;
        logic [NDW-1:0] ndig;
    } mac_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mac_sts_t;

endpackage

// ===== rtl/fng_if.sv =====
interface fng_face_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;

    modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface fng_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] group_index;
    logic       new_group;
    logic       table_full;

    modport source (output valid, group_index, new_group, table_full, input ready);
    modport sink (input valid, group_index, new_group, table_full, output ready);
endinterface

interface fng_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fng_cell.sv =====
module fng_cell (
    input  logic          clk,
    input  logic          shift,
    input  logic          load,
    input  fng_pkg::cell_t d_in,
    input  fng_pkg::cell_t ld_data,
    output fng_pkg::cell_t q
);
    import fng_pkg::*;

    cell_t q_reg;

    // One stored group normal; the ring moves every entry one place per shift.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= ld_data;
        end
        else if (shift)
        begin
            q_reg <= d_in;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/fng_mac.sv =====
module fng_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fng_pkg::mac_req_t            req,
    input  logic [fng_pkg::AW-1:0]       a,
    input  logic [fng_pkg::BW-1:0]       b,
    output fng_pkg::mac_sts_t            sts,
    output logic [fng_pkg::PW-1:0]       prod
);
    import fng_pkg::*;

    logic [AW-1:0]      a_reg, a_next;
    logic [BW-1:0]      b_reg, b_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [NDW-1:0]     cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [AW+DIGW-1:0] pp;
    logic [6:0]         align_sh;

    // Digits are consumed most significant first, so the multiplier is
    // left-aligned at start and the accumulator shifts one digit per cycle.
    assign align_sh = {3'(NDIG_WIDE - req.ndig), 3'b000} + 7'(0);
    assign pp       = (AW+DIGW)'(a_reg) * (AW+DIGW)'(b_reg[BW-1 -: DIGW]);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next   = a;
            b_next   = b << align_sh;
            acc_next = '0;
            cnt_next = req.ndig;
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = (acc_reg << DIGW) + PW'(pp);
            b_next    = b_reg << DIGW;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == NDW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign prod     = acc_reg;

endmodule

// ===== rtl/face_normal_grouper_top.sv =====
// Channel  | Modport | Moves per transaction
// ---------+---------+------------------------------------------------
// face     | sink    | cmd and three vertices (or a given normal)
// result   | source  | group_index, new_group, table_full
// cfg      | sink    | register index and write data
//
// A clear command goes straight to the done state and from there into the output register.
// A classify transaction computes the normal (unless a given normal is used), its
// squared length and the threshold product, then compares with each stored group in turn
// (with no multiplies when either normal is zero), then turns the ring home.
// All products go through one 104x8 multiply-accumulate unit, one digit a cycle.
// rst_n clears control state, the group count and the registers; the ring needs no clear.
// A new face is taken only when idle; a finished result may wait in the output register.

`include "face_normal_grouper_top_defines.svh"

module face_normal_grouper_top #(
    parameter int MAX_GROUPS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    fng_face_if.sink       face,
    fng_result_if.source   result,
    fng_cfg_if.sink        cfg
);
    import fng_pkg::*;

    localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);

    // Control state.
    state_t             state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    logic               issued_reg, issued_next;
    logic               use_geom_reg, use_geom_next;
    logic [TOL_W-1:0]   tol_reg, tol_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      scan_reg, scan_next;
    logic [IW-1:0]      rot_reg, rot_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath registers.
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] v_next [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic [NNW-1:0]       nn_reg, nn_next;
    logic [AW-1:0]        rt_reg, rt_next;
    logic [LW-1:0]        sq_reg, sq_next;
    logic signed [SW-1:0] sacc_reg, sacc_next;
    logic [GI_W-1:0]      pend_gi_reg, pend_gi_next;
    logic                 pend_ng_reg, pend_ng_next;
    logic                 pend_tf_reg, pend_tf_next;
    logic [GI_W-1:0]      out_gi_reg, out_gi_next;
    logic                 out_ng_reg, out_ng_next;
    logic                 out_tf_reg, out_tf_next;

    // Multiply unit and ring.
    mac_req_t             mac_req;
    mac_sts_t             mac_sts;
    logic                 mac_start;
    logic [NDW-1:0]       mac_ndig;
    logic [AW-1:0]        mac_a;
    logic [BW-1:0]        mac_b;
    logic [PW-1:0]        mac_prod;
    logic                 ring_shift;
    logic                 ring_load;
    cell_t                cell_q [MAX_GROUPS];
    cell_t                ld_cell;
    cell_t                head;

    // Operand selection.
    logic signed [DW-1:0] cp;
    logic signed [DW-1:0] cq;
    logic signed [NW-1:0] n_pick;
    logic signed [NW-1:0] m_pick;
    logic [NW-1:0]        n_mag;
    logic [NW-1:0]        m_mag;
    logic [DW-1:0]        cp_mag;
    logic [DW-1:0]        cq_mag;
    logic [SW-1:0]        dot_mag;
    logic                 neg;
    logic signed [SW-1:0] sacc_acc;
    logic [DW-1:0]        t_val;
    logic                 n_zero;
    logic                 face_acc;
    logic [IW-1:0]        rot_inc;

    assign head     = cell_q[0];
    assign t_val    = 17'h10000 - {1'b0, tol_reg};
    assign n_zero   = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
    assign face_acc = face.valid && face.ready;
    assign rot_inc  = (rot_reg == IW'(MAX_GROUPS - 1)) ? '0 : rot_reg + 1'b1;

    assign ld_cell.x  = n_reg[0];
    assign ld_cell.y  = n_reg[1];
    assign ld_cell.z  = n_reg[2];
    assign ld_cell.mm = nn_reg;

    assign mac_req = '{start: mac_start, ndig: mac_ndig};

    // The group table is a ring of cells. Cell i takes from cell i+1, so after
    // k shifts cell 0 holds group k; the scan always compares against cell 0.
    for (genvar gi = 0; gi < MAX_GROUPS; gi++)
    begin : g_ring
        fng_cell u_cell (
            .clk     (clk),
            .shift   (ring_shift),
            .load    ((gi == 0) ? ring_load : 1'b0),
            .d_in    (cell_q[(gi + 1) % MAX_GROUPS]),
            .ld_data (ld_cell),
            .q       (cell_q[gi])
        );
    end

    fng_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .a     (mac_a),
        .b     (mac_b),
        .sts   (mac_sts),
        .prod  (mac_prod)
    );

    // Operand pairs for the six cross-product terms, in the order nx, ny, nz, and the x, y, z pairs of the dot product.
    always_comb
    begin
        case (step_reg)
            3'd0:    begin cp = u_reg[1]; cq = v_reg[2]; end
            3'd1:    begin cp = u_reg[2]; cq = v_reg[1]; end
            3'd2:    begin cp = u_reg[2]; cq = v_reg[0]; end
            3'd3:    begin cp = u_reg[0]; cq = v_reg[2]; end
            3'd4:    begin cp = u_reg[0]; cq = v_reg[1]; end
            default: begin cp = u_reg[1]; cq = v_reg[0]; end
        endcase
        case (step_reg[1:0])
            2'd0:    begin n_pick = n_reg[0]; m_pick = head.x; end
            2'd1:    begin n_pick = n_reg[1]; m_pick = head.y; end
            default: begin n_pick = n_reg[2]; m_pick = head.z; end
        endcase
    end

    assign cp_mag  = cp[DW-1] ? DW'(-cp) : DW'(cp);
    assign cq_mag  = cq[DW-1] ? DW'(-cq) : DW'(cq);
    assign n_mag   = n_pick[NW-1] ? NW'(-n_pick) : NW'(n_pick);
    assign m_mag   = m_pick[NW-1] ? NW'(-m_pick) : NW'(m_pick);
    assign dot_mag = sacc_reg[SW-1] ? SW'(-sacc_reg) : SW'(sacc_reg);

    // Multiplier operands are magnitudes; the sign is applied when accumulating.
    always_comb
    begin
        mac_a    = AW'(n_mag);
        mac_b    = BW'(n_mag);
        mac_ndig = NDIG_NORMAL;
        neg      = 1'b0;
        unique case (state_reg)
            ST_CROSS:
            begin
                mac_a    = AW'(cp_mag);
                mac_b    = BW'(cq_mag);
                mac_ndig = NDIG_COORD;
                neg      = cp[DW-1] ^ cq[DW-1] ^ step_reg[0];
            end
            ST_RT:
            begin
                mac_a    = (step_reg == 3'd0) ? AW'(nn_reg) : rt_reg;
                mac_b    = BW'(t_val);
                mac_ndig = NDIG_COORD;
            end
            ST_DOT:
            begin
                mac_b = BW'(m_mag);
                neg   = n_pick[NW-1] ^ m_pick[NW-1];
            end
            ST_SQ:
            begin
                mac_a    = AW'(dot_mag);
                mac_b    = dot_mag;
                mac_ndig = NDIG_WIDE;
            end
            ST_RM:
            begin
                mac_a    = rt_reg;
                mac_b    = BW'(head.mm);
                mac_ndig = NDIG_WIDE;
            end
            default:
            begin
                mac_a    = AW'(n_mag);
                mac_b    = BW'(n_mag);
                mac_ndig = NDIG_NORMAL;
            end
        endcase
    end

    assign sacc_acc = neg ? sacc_reg - $signed(mac_prod[SW-1:0])
                          : sacc_reg + $signed(mac_prod[SW-1:0]);

    // Sequencer. Every multiply state starts the unit once per step, then waits for done.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        issued_next    = issued_reg;
        use_geom_next  = use_geom_reg;
        tol_next       = tol_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rot_next       = rot_reg;
        out_valid_next = out_valid_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        n_next         = n_reg;
        nn_next        = nn_reg;
        rt_next        = rt_reg;
        sq_next        = sq_reg;
        sacc_next      = sacc_reg;
        pend_gi_next   = pend_gi_reg;
        pend_ng_next   = pend_ng_reg;
        pend_tf_next   = pend_tf_reg;
        out_gi_next    = out_gi_reg;
        out_ng_next    = out_ng_reg;
        out_tf_next    = out_tf_reg;
        mac_start      = 1'b0;
        ring_shift     = 1'b0;
        ring_load      = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_USE_GEOM:  use_geom_next = cfg.data[0];
                REG_TOLERANCE: tol_next      = cfg.data;
                default:       tol_next      = tol_reg;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (face_acc)
                begin
                    step_next   = '0;
                    issued_next = 1'b0;
                    sacc_next   = '0;
                    scan_next   = '0;
                    u_next[0]   = DW'(face.b_x) - DW'(face.a_x);
                    u_next[1]   = DW'(face.b_y) - DW'(face.a_y);
                    u_next[2]   = DW'(face.b_z) - DW'(face.a_z);
                    v_next[0]   = DW'(face.c_x) - DW'(face.b_x);
                    v_next[1]   = DW'(face.c_y) - DW'(face.b_y);
                    v_next[2]   = DW'(face.c_z) - DW'(face.b_z);
                    n_next[0]   = NW'(face.a_x);
                    n_next[1]   = NW'(face.a_y);
                    n_next[2]   = NW'(face.a_z);
                    if (face.cmd == CMD_CLEAR)
                    begin
                        count_next   = '0;
                        pend_gi_next = '0;
                        pend_ng_next = 1'b0;
                        pend_tf_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = use_geom_reg ? ST_CROSS : ST_NN;
                    end
                end
            end
            ST_CROSS, ST_NN, ST_RT, ST_DOT, ST_SQ, ST_RM:
            begin
                if (!issued_reg)
                begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mac_sts.done)
                begin
                    issued_next = 1'b0;
                    step_next   = step_reg + 1'b1;
                    unique case (state_reg)
                        ST_CROSS:
                        begin
                            sacc_next = sacc_acc;
                            if (step_reg[0])
                            begin
                                n_next[step_reg[2:1]] = sacc_acc[NW-1:0];
                                sacc_next             = '0;
                            end
                            if (step_reg == 3'd5)
                            begin
                                step_next  = '0;
                                state_next = ST_NN;
                            end
                        end
                        ST_NN:
                        begin
                            sacc_next = sacc_acc;
                            if (step_reg == 3'd2)
                            begin
                                nn_next    = sacc_acc[NNW-1:0];
                                sacc_next  = '0;
                                step_next  = '0;
                                state_next = ST_RT;
                            end
                        end
                        ST_RT:
                        begin
                            rt_next = mac_prod[AW-1:0];
                            if (step_reg == 3'd1)
                            begin
                                step_next  = '0;
                                state_next = (count_reg == '0) ? ST_NEWG : ST_CHECK;
                            end
                        end
                        ST_DOT:
                        begin
                            sacc_next = sacc_acc;
                            if (step_reg == 3'd2)
                            begin
                                step_next  = '0;
                                state_next = ST_SQ;
                            end
                        end
                        ST_SQ:
                        begin
                            sq_next    = mac_prod[LW-1:0];
                            step_next  = '0;
                            state_next = ST_RM;
                        end
                        default:
                        begin
                            // Squared test: dot^2 * 2^32 against t^2 * |n|^2 * |m|^2.
                            step_next = '0;
                            if ({sq_reg, FRAC_SH'(0)} > mac_prod)
                            begin
                                pend_gi_next = GI_W'(scan_reg);
                                pend_ng_next = 1'b0;
                                pend_tf_next = 1'b0;
                                state_next   = ST_RESTORE;
                            end
                            else
                            begin
                                ring_shift = 1'b1;
                                rot_next   = rot_inc;
                                if (CW'(scan_reg) + CW'(1) == count_reg)
                                begin
                                    state_next = ST_NEWG;
                                end
                                else
                                begin
                                    scan_next  = scan_reg + 1'b1;
                                    state_next = ST_CHECK;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                // A zero normal on either side never matches.
                if (n_zero || (head.mm == '0))
                begin
                    ring_shift = 1'b1;
                    rot_next   = rot_inc;
                    if (CW'(scan_reg) + CW'(1) == count_reg)
                    begin
                        state_next = ST_NEWG;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                else
                begin
                    sacc_next  = '0;
                    step_next  = '0;
                    state_next = ST_DOT;
                end
            end
            ST_NEWG:
            begin
                // The ring has turned count_reg places, so cell 0 is the free slot.
                if (count_reg != CW'(MAX_GROUPS))
                begin
                    ring_load    = 1'b1;
                    pend_gi_next = GI_W'(count_reg);
                    pend_ng_next = 1'b1;
                    pend_tf_next = 1'b0;
                    count_next   = count_reg + 1'b1;
                end
                else
                begin
                    pend_gi_next = '0;
                    pend_ng_next = 1'b0;
                    pend_tf_next = 1'b1;
                end
                state_next = ST_RESTORE;
            end
            ST_RESTORE:
            begin
                // Turn the ring on until group 0 is back in cell 0.
                if (rot_reg != '0)
                begin
                    ring_shift = 1'b1;
                    rot_next   = rot_inc;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_gi_next    = pend_gi_reg;
                    out_ng_next    = pend_ng_reg;
                    out_tf_next    = pend_tf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            issued_reg    <= 1'b0;
            use_geom_reg  <= USE_GEOM_RST;
            tol_reg       <= TOLERANCE_RST;
            count_reg     <= '0;
            scan_reg      <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            issued_reg    <= issued_next;
            use_geom_reg  <= use_geom_next;
            tol_reg       <= tol_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg       <= u_next;
        v_reg       <= v_next;
        n_reg       <= n_next;
        nn_reg      <= nn_next;
        rt_reg      <= rt_next;
        sq_reg      <= sq_next;
        sacc_reg    <= sacc_next;
        pend_gi_reg <= pend_gi_next;
        pend_ng_reg <= pend_ng_next;
        pend_tf_reg <= pend_tf_next;
        out_gi_reg  <= out_gi_next;
        out_ng_reg  <= out_ng_next;
        out_tf_reg  <= out_tf_next;
    end

    assign face.ready         = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.group_index = out_gi_reg;
    assign result.new_group   = out_ng_reg;
    assign result.table_full  = out_tf_reg;

    // The group count never passes the table size.
    `FNG_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(MAX_GROUPS))
    // Between transactions the ring is back in its home position.
    `FNG_ASSERT_IMP(a_ring_home, state_reg == ST_IDLE, rot_reg == '0)
    // A result cannot both open a group and report a full table.
    `FNG_ASSERT_IMP(a_new_not_full, result.valid && result.new_group, !result.table_full)
    // The multiply unit is never restarted while it still has digits to go.
    `FNG_ASSERT_IMP(a_mac_no_restart, mac_req.start, !mac_sts.busy)
    // A clear command always empties the table by the next cycle.
    `FNG_ASSERT_NEXT(a_clear_empties, face_acc && (face.cmd == CMD_CLEAR), count_reg == '0)

endmodule
